// ----- hdl/grid_square_rotator_unit_assert.svh -----
// Assertion macros for the grid square rotator checker.
`ifndef GRID_SQUARE_ROTATOR_UNIT_ASSERT_SVH
`define GRID_SQUARE_ROTATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GSR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define GSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gsr_pkg.sv -----
// Shared constants and types for the grid square rotator.
package gsr_pkg;
    localparam int DEF_MAX_SIDE = 1024;
    localparam int COORD_W      = 11;
    localparam int CELL_W       = 8;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_ROTATE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic REG_GRID_SIDE = 1'b0;

    typedef struct packed {
        logic       load;     // item accepted this cycle
        logic       rot;      // rotation sequencing active
        logic [2:0] step;     // 0..3 read corners, 4..7 write corners
        logic       adv;      // move on to next ring group
        logic       out_load; // load result register
        logic       out_mem;  // result takes memory read data
    } t_cmd;

    typedef struct packed {
        logic bad;        // incoming item flagged
        logic ring_empty; // incoming rotate moves nothing
        logic ring_last;  // current group is the final one
    } t_status;
endpackage

// ----- hdl/gsr_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface gsr_req_if import gsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] square_side;
    logic [CELL_W-1:0]  cell_value;
    modport source (output valid, req_type, row, column, square_side, cell_value,
                    input ready);
    modport sink (input valid, req_type, row, column, square_side, cell_value,
                  output ready);
endinterface

interface gsr_rsp_if import gsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] read_value;
    logic              out_of_range;
    modport source (output valid, read_value, out_of_range, input ready);
    modport sink (input valid, read_value, out_of_range, output ready);
endinterface

// ----- hdl/gsr_ctrl.sv -----
// Controller: item handshake, result valid and rotation sequencing.
module gsr_ctrl import gsr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [1:0] i_req_type,
    input  logic       i_rsp_ready,
    input  t_status    i_status,
    output logic       o_req_ready,
    output logic       o_rsp_valid,
    output t_cmd       o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_RD, S_ROT} t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_rsp_valid, n_rsp_valid;
    logic       accept;

    assign o_req_ready = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign accept      = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_cmd         = '0;
        o_cmd.step    = r_step;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_req_type == REQ_ROTATE && !i_status.bad &&
                        !i_status.ring_empty) begin
                        n_state = S_ROT;
                        n_step  = '0;
                    end else if (i_req_type == REQ_READ && !i_status.bad) begin
                        n_state = S_RD;
                    end else begin
                        o_cmd.out_load = 1'b1;
                    end
                end
            end
            S_RD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_mem  = 1'b1;
                n_state        = S_IDLE;
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                n_step    = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    if (i_status.ring_last) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.adv = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_rsp_valid = o_cmd.out_load ? 1'b1 : (r_rsp_valid && !i_rsp_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_rsp_valid <= n_rsp_valid;
        end
    end
endmodule

// ----- hdl/gsr_datapath.sv -----
// Datapath: cell memory, bounds check, corner addressing and result register.
module gsr_datapath import gsr_pkg::*; #(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic               i_clk,
    input  logic [COORD_W-1:0] i_grid_side,
    input  logic [1:0]         i_req_type,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_column,
    input  logic [COORD_W-1:0] i_square_side,
    input  logic [CELL_W-1:0]  i_cell_value,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic [CELL_W-1:0]  o_read_value,
    output logic               o_out_of_range
);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = COORD_W + 1;

    logic [CELL_W-1:0]  mem [DEPTH];
    logic [CELL_W-1:0]  r_rdata;
    logic [CELL_W-1:0]  r_v [4];
    logic [COORD_W-1:0] r_r0, r_c0, r_n, r_i, r_j;
    logic [CELL_W-1:0]  r_read_value;
    logic               r_out_of_range;

    logic [XW-1:0] g, row_x, col_x, side_x, row_end, col_end;
    logic [XW-1:0] nm1, cr, cc, in_r, in_c;
    logic [AW-1:0] addr, in_addr, rot_addr;
    logic          we;
    logic          bad;
    logic [CELL_W-1:0] wdata;
    logic [1:0]    sel;

    // used side, clamped to the memory
    assign g      = (32'(i_grid_side) > 32'(MAX_SIDE)) ? XW'(MAX_SIDE) : XW'(i_grid_side);
    assign row_x  = XW'(i_row);
    assign col_x  = XW'(i_column);
    assign side_x = XW'(i_square_side);
    assign row_end = row_x + side_x - XW'(1);
    assign col_end = col_x + side_x - XW'(1);

    always_comb begin
        bad = 1'b0;
        if (i_req_type == REQ_WRITE || i_req_type == REQ_READ)
            bad = (row_x == '0) || (col_x == '0) || (row_x > g) || (col_x > g);
        else if (i_req_type == REQ_ROTATE)
            bad = (row_x == '0) || (col_x == '0) || (side_x == '0) ||
                  (row_end > g) || (col_end > g);
    end
    assign o_status.bad        = bad;
    assign o_status.ring_empty = (i_square_side < COORD_W'(2));
    assign o_status.ring_last  = ((XW'(r_i) + XW'(r_j) + XW'(2)) >= XW'(r_n)) &&
                                 ((r_i + COORD_W'(1)) >= (r_n >> 1));

    // corner of the current four-cell cycle
    assign sel = i_cmd.step[1:0];
    assign nm1 = XW'(r_n) - XW'(1);
    always_comb begin
        case (sel)
            2'd0: begin cr = XW'(r_i);       cc = XW'(r_j);       end
            2'd1: begin cr = XW'(r_j);       cc = nm1 - XW'(r_i); end
            2'd2: begin cr = nm1 - XW'(r_i); cc = nm1 - XW'(r_j); end
            default: begin cr = nm1 - XW'(r_j); cc = XW'(r_i); end
        endcase
        cr = cr + XW'(r_r0);
        cc = cc + XW'(r_c0);
    end

    assign in_r     = row_x - XW'(1);
    assign in_c     = col_x - XW'(1);
    assign in_addr  = AW'(32'(in_r) * 32'(MAX_SIDE) + 32'(in_c));
    assign rot_addr = AW'(32'(cr) * 32'(MAX_SIDE) + 32'(cc));
    assign addr     = i_cmd.rot ? rot_addr : in_addr;

    assign we    = (i_cmd.load && i_req_type == REQ_WRITE && !bad) ||
                   (i_cmd.rot && i_cmd.step[2]);
    assign wdata = i_cmd.rot ? r_v[sel + 2'd1] : i_cell_value;

    always_ff @(posedge i_clk) begin
        if (we)
            mem[addr] <= wdata;
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r0 <= i_row - COORD_W'(1);
            r_c0 <= i_column - COORD_W'(1);
            r_n  <= i_square_side;
            r_i  <= '0;
            r_j  <= '0;
        end else if (i_cmd.adv) begin
            if ((XW'(r_j) + XW'(r_i) + XW'(2)) < XW'(r_n)) begin
                r_j <= r_j + COORD_W'(1);
            end else begin
                r_i <= r_i + COORD_W'(1);
                r_j <= r_i + COORD_W'(1);
            end
        end
        // read data of corner k arrives in the step after its read
        if (i_cmd.rot && i_cmd.step != 3'd0 && !i_cmd.step[2])
            r_v[2'(i_cmd.step - 3'd1)] <= r_rdata;
        if (i_cmd.rot && i_cmd.step == 3'd4)
            r_v[3] <= r_rdata;
        if (i_cmd.out_load) begin
            r_read_value   <= i_cmd.out_mem ? r_rdata : '0;
            r_out_of_range <= i_cmd.load ? bad : 1'b0;
        end
    end

    assign o_read_value   = r_read_value;
    assign o_out_of_range = r_out_of_range;
endmodule

// ----- hdl/grid_square_rotator_unit.sv -----
// Grid square rotator: a grid of 8-bit cells with write, read and in-place rotate items.
// A write, an unused kind or a flagged item sets its result on acceptance, a read after its
// S_RD state; the next item is taken in the cycle that the waiting result is taken. A rotate
// of side n walks floor(n*n/4) four-cell groups through the single-port cell memory, each as
// four reads then four writes. The memory holds MAX_SIDE*MAX_SIDE cells and is not cleared;
// grid_side sits at byte address 0 of the APB port, reset value 1.
module grid_square_rotator_unit import gsr_pkg::*; #(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsr_req_if.sink     i_req,
    gsr_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [COORD_W-1:0] r_grid_side;
    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GRID_SIDE) ? 32'(r_grid_side) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= COORD_W'(1);
        end else if (psel && penable && pwrite && paddr[2] == REG_GRID_SIDE) begin
            r_grid_side <= pwdata[COORD_W-1:0];
        end
    end

    gsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (status),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    gsr_datapath #(.MAX_SIDE(MAX_SIDE)) u_dp (
        .i_clk          (i_clk),
        .i_grid_side    (r_grid_side),
        .i_req_type     (i_req.req_type),
        .i_row          (i_req.row),
        .i_column       (i_req.column),
        .i_square_side  (i_req.square_side),
        .i_cell_value   (i_req.cell_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_read_value   (o_rsp.read_value),
        .o_out_of_range (o_rsp.out_of_range)
    );
endmodule

// ----- hdl/gsr_checker.sv -----
// Port-level checker for the grid square rotator, bound to the top level.
`include "grid_square_rotator_unit_assert.svh"
module gsr_checker import gsr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic [1:0]        i_req_type,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [CELL_W-1:0] i_read_value,
    input logic              i_out_of_range
);
    logic acc;
    assign acc = i_req_valid && i_req_ready;

    `GSR_ASSERT_IMPL(a_flag_zero, i_rsp_valid && i_out_of_range, i_read_value == '0, "flagged item with nonzero data")
    `GSR_ASSERT_NEXT(a_write_rsp, acc && i_req_type == REQ_WRITE, i_rsp_valid && i_read_value == '0, "write result missing or nonzero")
    `GSR_ASSERT_NEXT(a_unused_rsp, acc && i_req_type == REQ_UNUSED, i_rsp_valid && !i_out_of_range && i_read_value == '0, "unused kind result wrong")
    `GSR_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_read_value) && $stable(i_out_of_range), "stalled result changed")
endmodule

bind grid_square_rotator_unit gsr_checker u_gsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_type     (i_req.req_type),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_read_value   (o_rsp.read_value),
    .i_out_of_range (o_rsp.out_of_range)
);
